// ===== rtl/core/mmda_pkg.sv =====
// package for the modular multiplier, double-and-add
// holds the default operand width, controller states and the command/status structs
// no dependencies
package mmda_pkg;

  localparam int OPERAND_WIDTH_DEF = 31;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_MULT,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic reduce_step;
    logic mult_step;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic count_last;
  } status_t;

endpackage

// ===== rtl/core/mmda_ctrl.sv =====
// controller state machine for the modular multiplier
// sequences load, reduction, double-and-add steps and result transfer
// depends on mmda_pkg
module mmda_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  output logic             out_valid,
  input  logic             out_stall,
  input  mmda_pkg::status_t status,
  output mmda_pkg::cmd_t   cmd
);
  import mmda_pkg::*;

  state_t state;
  state_t state_next;
  logic   out_free;

  assign out_free = !out_valid || !out_stall;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_REDUCE;
      end
      ST_REDUCE: begin
        if (status.count_last) state_next = ST_MULT;
      end
      ST_MULT: begin
        if (status.count_last) state_next = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_stall = 1'b1;
    unique case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      ST_REDUCE: cmd.reduce_step = 1'b1;
      ST_MULT:   cmd.mult_step = 1'b1;
      ST_DONE:   cmd.emit = out_free;
      default:   cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // a new result never overwrites one that is still waiting
  assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (!out_valid || !out_stall))
    else $error("result overwritten before transfer");

  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(cmd.emit))
    else $error("out_valid rose without a result");

  assert property (@(posedge clk) disable iff (rst)
    (state == ST_REDUCE && status.count_last) |=> state == ST_MULT)
    else $error("reduction did not hand over to multiply");

endmodule

// ===== rtl/core/mmda_dp.sv =====
// datapath for the modular multiplier: operand registers, bit counter,
// restoring reduction step, double-and-add step and result register
// depends on mmda_pkg
module mmda_dp #(
  parameter int OPERAND_WIDTH = mmda_pkg::OPERAND_WIDTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  mmda_pkg::cmd_t           cmd,
  output mmda_pkg::status_t        status,
  input  logic [OPERAND_WIDTH-1:0] multiplicand,
  input  logic [OPERAND_WIDTH-1:0] multiplier,
  input  logic [OPERAND_WIDTH-1:0] modulus,
  output logic [OPERAND_WIDTH-1:0] product_mod
);
  import mmda_pkg::*;

  localparam int W  = OPERAND_WIDTH;
  localparam int CW = $clog2(W);
  localparam int XW = W + 2;
  localparam logic [CW-1:0] COUNT_TOP = CW'(W - 1);

  logic [W-1:0]  a;
  logic [W-1:0]  b;
  logic [W-1:0]  m;
  logic [W-1:0]  r;
  logic [W-1:0]  ar;
  logic          mod_zero;
  logic [CW-1:0] count;

  logic [W:0]    red_shift;
  logic [W-1:0]  red_next;
  logic [XW-1:0] m_x;
  logic [XW-1:0] m2_x;
  logic [XW-1:0] t;
  logic [XW-1:0] t_m1;
  logic [XW-1:0] t_m2;
  logic [W-1:0]  mult_next;

  assign status.count_last = (count == '0);

  // one restoring reduction step
  always_comb begin
    red_shift = {r, a[W-1]};
    if (red_shift >= {1'b0, m}) begin
      red_next = W'(red_shift - {1'b0, m});
    end else begin
      red_next = red_shift[W-1:0];
    end
  end

  // double, add when the multiplier bit is set, reduce; sum stays below 3m
  always_comb begin
    m_x  = XW'(m);
    m2_x = XW'({m, 1'b0});
    t    = XW'({r, 1'b0}) + (b[W-1] ? XW'(ar) : XW'(0));
    t_m1 = t - m_x;
    t_m2 = t - m2_x;
    if (t >= m2_x) begin
      mult_next = t_m2[W-1:0];
    end else if (t >= m_x) begin
      mult_next = t_m1[W-1:0];
    end else begin
      mult_next = t[W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= COUNT_TOP;
    end else if (cmd.load) begin
      count <= COUNT_TOP;
    end else if (cmd.reduce_step || cmd.mult_step) begin
      count <= status.count_last ? COUNT_TOP : count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      a <= multiplicand;
      b <= multiplier;
      m <= modulus;
      mod_zero <= (modulus == '0);
      r <= '0;
    end else if (cmd.reduce_step) begin
      a <= {a[W-2:0], 1'b0};
      if (status.count_last) begin
        ar <= red_next;
        r <= '0;
      end else begin
        r <= red_next;
      end
    end else if (cmd.mult_step) begin
      b <= {b[W-2:0], 1'b0};
      r <= mult_next;
    end
    if (cmd.emit) begin
      product_mod <= mod_zero ? '0 : r;
    end
  end

  // finished residue lies below the modulus
  assert property (@(posedge clk) disable iff (rst)
    (cmd.emit && !mod_zero) |-> (r < m))
    else $error("residue not below modulus");

  assert property (@(posedge clk) disable iff (rst)
    (cmd.reduce_step && status.count_last && !mod_zero) |=> (ar < m))
    else $error("reduced multiplicand not below modulus");

endmodule

// ===== rtl/core/modular_multiply_double_add.sv =====
// top level of the modular multiplier, double-and-add
// joins controller mmda_ctrl and datapath mmda_dp; depends on mmda_pkg
//
// channel  direction  handshake            payload
// in       input      in_valid / in_stall  multiplicand, multiplier, modulus
// out      output     out_valid / out_stall product_mod
//
// after transfer an item runs one reduction step and one double-and-add step per
// operand bit in the datapath, and then its result is registered
// a new item is taken only after the last one has moved into the result register
// the result register lets the next item start while a result waits on out
// reset clears the controller, the bit counter and out_valid; no other register is reset
module modular_multiply_double_add #(
  parameter int OPERAND_WIDTH = mmda_pkg::OPERAND_WIDTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [OPERAND_WIDTH-1:0] multiplicand,
  input  logic [OPERAND_WIDTH-1:0] multiplier,
  input  logic [OPERAND_WIDTH-1:0] modulus,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [OPERAND_WIDTH-1:0] product_mod
);
  import mmda_pkg::*;

  cmd_t    cmd;
  status_t status;

  mmda_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  mmda_dp #(
    .OPERAND_WIDTH (OPERAND_WIDTH)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .multiplicand (multiplicand),
    .multiplier   (multiplier),
    .modulus      (modulus),
    .product_mod  (product_mod)
  );

endmodule
